// ----- hw/rtl/wsb_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and codes for the wrapped scroll blit splitter
// no dependencies

package wsb_pkg;

  localparam int COORD_BITS     = 12;
  localparam int STATE_BITS     = COORD_BITS + 2;
  localparam int DEST_BITS      = COORD_BITS + 3;
  localparam int IN_BITS        = COORD_BITS + 1;
  localparam int CALC_BITS      = COORD_BITS + 4;
  localparam int SPEED_BITS     = 8;
  localparam int DIR_BITS       = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [STATE_BITS-1:0] view_t;
  typedef logic signed [IN_BITS-1:0]    pos_t;
  typedef logic signed [DEST_BITS-1:0]  dest_t;
  typedef logic [SPEED_BITS-1:0]        speed_t;
  typedef logic [DIR_BITS-1:0]          dir_t;
  typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

  // item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // scroll directions, codes above DIR_NONE also hold still
  localparam dir_t DIR_UP    = 3'd0;
  localparam dir_t DIR_RIGHT = 3'd1;
  localparam dir_t DIR_DOWN  = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_NONE  = 3'd4;

  // register indexes
  localparam cfg_index_t REG_IMAGE_WIDTH      = 3'd0;
  localparam cfg_index_t REG_IMAGE_HEIGHT     = 3'd1;
  localparam cfg_index_t REG_SCROLL_SPEED     = 3'd2;
  localparam cfg_index_t REG_SCROLL_DIRECTION = 3'd3;

  localparam coord_t WIDTH_RESET  = COORD_BITS'(640);
  localparam coord_t HEIGHT_RESET = COORD_BITS'(480);
  localparam speed_t SPEED_RESET  = 8'd1;

  // one axis of the wrapped view: first span starts at destination 0 and
  // the second span, when present, has source 0
  typedef struct packed {
    logic                 two;
    logic [DEST_BITS-1:0] d1;
    coord_t               s0;
    coord_t               n0;
    coord_t               n1;
  } span_t;

endpackage

// ----- hw/rtl/wrapped_scroll_blit_splitter.sv -----
`timescale 1ns / 1ps
// top level of the wrapped scroll blit splitter: registers, input stage, glue
// depends on wsb_pkg, wsb_view, wsb_axis_split, wsb_emit

// Keeps a viewport offset (left, top) into a background image that repeats,
// the viewport being the full image size. A tick item (mode 0) moves the
// offset by scroll_speed in scroll_direction and snaps it back to zero once it
// runs past the image edge; it gives no output item. A draw item (mode 1)
// gives one, two or four copy rectangles, row by row and left to right, the
// final one flagged by last_part. Items land in an input register; from there
// a tick retires without waiting, and a draw is split combinationally into a
// holding stage that feeds one rectangle per cycle, unless part_stall holds
// the single output register, into that register. A new item is taken while
// rectangles of the previous one are still waiting to be taken. cfg_ready is
// always high; register writes are meant to happen only while the block is
// idle and do not move the viewport. Indexes beyond scroll_direction are
// ignored.

module wrapped_scroll_blit_splitter (
  input  logic                clk,
  input  logic                rst,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  wsb_pkg::cfg_index_t cfg_index,
  input  wsb_pkg::cfg_data_t  cfg_data,
  // input items
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                mode,
  input  wsb_pkg::pos_t       draw_x,
  input  wsb_pkg::pos_t       draw_y,
  // output rectangles
  output logic                part_valid,
  input  logic                part_stall,
  output wsb_pkg::dest_t      dest_x,
  output wsb_pkg::dest_t      dest_y,
  output wsb_pkg::coord_t     src_x,
  output wsb_pkg::coord_t     src_y,
  output wsb_pkg::coord_t     part_width,
  output wsb_pkg::coord_t     part_height,
  output logic                last_part
);
  import wsb_pkg::*;

  // configuration registers
  coord_t image_width, image_height;
  speed_t scroll_speed;
  dir_t   scroll_direction;

  // input register
  logic a_valid;
  logic a_mode;
  pos_t a_x, a_y;

  logic  item_take, a_leave, tick_fire, split_load, emit_ready;
  view_t view_left, view_top;
  span_t cols, rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RESET;
      image_height     <= HEIGHT_RESET;
      scroll_speed     <= SPEED_RESET;
      scroll_direction <= DIR_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:      image_width      <= cfg_data;
        REG_IMAGE_HEIGHT:     image_height     <= cfg_data;
        REG_SCROLL_SPEED:     scroll_speed     <= cfg_data[SPEED_BITS-1:0];
        REG_SCROLL_DIRECTION: scroll_direction <= cfg_data[DIR_BITS-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // a tick always leaves the input register; a draw waits for the holding stage
  assign split_load = a_valid && (a_mode == MODE_DRAW) && emit_ready;
  assign tick_fire  = a_valid && (a_mode == MODE_TICK);
  assign a_leave    = tick_fire || split_load;
  assign item_stall = a_valid && !a_leave;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_take) begin
      a_valid <= 1'b1;
    end else if (a_leave) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      a_mode <= mode;
      a_x    <= draw_x;
      a_y    <= draw_y;
    end
  end

  // viewport offset, moved as each tick leaves the input register so that
  // draws see every earlier tick
  wsb_view u_view (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick_fire),
    .image_width      (image_width),
    .image_height     (image_height),
    .scroll_speed     (scroll_speed),
    .scroll_direction (scroll_direction),
    .view_left        (view_left),
    .view_top         (view_top)
  );

  // column and row split of the wrapped view
  wsb_axis_split u_split_cols (
    .off  (view_left),
    .size (image_width),
    .span (cols)
  );

  wsb_axis_split u_split_rows (
    .off  (view_top),
    .size (image_height),
    .span (rows)
  );

  // holding stage and output register
  wsb_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (split_load),
    .x           (a_x),
    .y           (a_y),
    .cols        (cols),
    .rows        (rows),
    .ready       (emit_ready),
    .part_valid  (part_valid),
    .part_stall  (part_stall),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .src_x       (src_x),
    .src_y       (src_y),
    .part_width  (part_width),
    .part_height (part_height),
    .last_part   (last_part)
  );

`ifndef SYNTH
  a_stall_only_on_draw: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> a_valid && (a_mode == MODE_DRAW) && !emit_ready)
    else $error("input stalled without a draw waiting on the holding stage");
`endif

endmodule

// ----- hw/rtl/wsb_axis_split.sv -----
`timescale 1ns / 1ps
// splits one axis of the wrapped viewport into one or two spans
// depends on wsb_pkg

module wsb_axis_split (
  input  wsb_pkg::view_t  off,
  input  wsb_pkg::coord_t size,
  output wsb_pkg::span_t  span
);
  import wsb_pkg::*;

  logic signed [CALC_BITS-1:0] off_w;
  logic signed [CALC_BITS-1:0] size_w;
  logic signed [CALC_BITS-1:0] neg_off;
  logic signed [CALC_BITS-1:0] rest;
  logic signed [CALC_BITS-1:0] diff;

  assign off_w   = CALC_BITS'(off);
  assign size_w  = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, size});
  assign neg_off = -off_w;
  assign rest    = size_w + off_w;
  assign diff    = size_w - off_w;

  always_comb begin
    if (off_w < 0) begin
      span.two = 1'b1;
      span.d1  = neg_off[DEST_BITS-1:0];
      span.s0  = rest[COORD_BITS-1:0];
      span.n0  = neg_off[COORD_BITS-1:0];
      span.n1  = rest[COORD_BITS-1:0];
    end else if (off_w > 0) begin
      span.two = 1'b1;
      span.d1  = diff[DEST_BITS-1:0];
      span.s0  = off_w[COORD_BITS-1:0];
      span.n0  = diff[COORD_BITS-1:0];
      span.n1  = off_w[COORD_BITS-1:0];
    end else begin
      span.two = 1'b0;
      span.d1  = '0;
      span.s0  = '0;
      span.n0  = size;
      span.n1  = '0;
    end
  end

endmodule

// ----- hw/rtl/wsb_view.sv -----
`timescale 1ns / 1ps
// viewport offset registers and the tick update with wrap to zero
// depends on wsb_pkg

module wsb_view (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick,
  input  wsb_pkg::coord_t image_width,
  input  wsb_pkg::coord_t image_height,
  input  wsb_pkg::speed_t scroll_speed,
  input  wsb_pkg::dir_t   scroll_direction,
  output wsb_pkg::view_t  view_left,
  output wsb_pkg::view_t  view_top
);
  import wsb_pkg::*;

  logic signed [CALC_BITS-1:0] left_w, top_w, spd_w, w_w, h_w;
  logic signed [CALC_BITS-1:0] top_up, top_dn, left_rt, left_lf;
  logic signed [CALC_BITS-1:0] top_dn_edge, left_rt_edge;
  view_t view_left_next, view_top_next;

  assign left_w  = CALC_BITS'(view_left);
  assign top_w   = CALC_BITS'(view_top);
  assign spd_w   = $signed({{(CALC_BITS-SPEED_BITS){1'b0}}, scroll_speed});
  assign w_w     = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, image_width});
  assign h_w     = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, image_height});

  assign top_up       = top_w + spd_w;
  assign top_dn       = top_w - spd_w;
  assign left_rt      = left_w - spd_w;
  assign left_lf      = left_w + spd_w;
  assign top_dn_edge  = top_dn + h_w;
  assign left_rt_edge = left_rt + w_w;

  always_comb begin
    view_left_next = view_left;
    view_top_next  = view_top;
    if (tick) begin
      case (scroll_direction)
        DIR_UP:    view_top_next  = (top_up > h_w) ? '0 : top_up[STATE_BITS-1:0];
        DIR_DOWN:  view_top_next  = (top_dn_edge < 0) ? '0 : top_dn[STATE_BITS-1:0];
        DIR_RIGHT: view_left_next = (left_rt_edge < 0) ? '0 : left_rt[STATE_BITS-1:0];
        DIR_LEFT:  view_left_next = (left_lf > w_w) ? '0 : left_lf[STATE_BITS-1:0];
        default: begin
          view_left_next = view_left;
          view_top_next  = view_top;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_left <= '0;
      view_top  <= '0;
    end else begin
      view_left <= view_left_next;
      view_top  <= view_top_next;
    end
  end

endmodule

// ----- hw/rtl/wsb_emit.sv -----
`timescale 1ns / 1ps
// holds one split draw request and issues its rectangles into the output register
// depends on wsb_pkg

module wsb_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  wsb_pkg::pos_t   x,
  input  wsb_pkg::pos_t   y,
  input  wsb_pkg::span_t  cols,
  input  wsb_pkg::span_t  rows,
  output logic            ready,
  output logic            part_valid,
  input  logic            part_stall,
  output wsb_pkg::dest_t  dest_x,
  output wsb_pkg::dest_t  dest_y,
  output wsb_pkg::coord_t src_x,
  output wsb_pkg::coord_t src_y,
  output wsb_pkg::coord_t part_width,
  output wsb_pkg::coord_t part_height,
  output logic            last_part
);
  import wsb_pkg::*;

  logic  b_valid;
  logic  col, row;
  pos_t  b_x, b_y;
  span_t b_cols, b_rows;

  logic o_free, emit, last_col, last_row, emit_last;
  logic [DEST_BITS-1:0] x_ext, y_ext, dx, dy;

  assign o_free    = !part_valid || !part_stall;
  assign emit      = b_valid && o_free;
  assign last_col  = !b_cols.two || col;
  assign last_row  = !b_rows.two || row;
  assign emit_last = last_col && last_row;
  assign ready     = !b_valid || (emit && emit_last);

  assign x_ext = DEST_BITS'(b_x);
  assign y_ext = DEST_BITS'(b_y);
  assign dx    = x_ext + (col ? b_cols.d1 : '0);
  assign dy    = y_ext + (row ? b_rows.d1 : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      col        <= 1'b0;
      row        <= 1'b0;
      part_valid <= 1'b0;
    end else begin
      if (load) begin
        b_valid <= 1'b1;
        col     <= 1'b0;
        row     <= 1'b0;
      end else if (emit && emit_last) begin
        b_valid <= 1'b0;
      end else if (emit) begin
        if (last_col) begin
          col <= 1'b0;
          row <= 1'b1;
        end else begin
          col <= 1'b1;
        end
      end
      if (emit) begin
        part_valid <= 1'b1;
      end else if (!part_stall) begin
        part_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_x    <= x;
      b_y    <= y;
      b_cols <= cols;
      b_rows <= rows;
    end
    if (emit) begin
      dest_x      <= $signed(dx);
      dest_y      <= $signed(dy);
      src_x       <= col ? '0 : b_cols.s0;
      src_y       <= row ? '0 : b_rows.s0;
      part_width  <= col ? b_cols.n1 : b_cols.n0;
      part_height <= row ? b_rows.n1 : b_rows.n0;
      last_part   <= emit_last;
    end
  end

`ifndef SYNTH
  a_col_needs_split: assert property (@(posedge clk) disable iff (rst)
    b_valid && col |-> b_cols.two)
    else $error("second column issued for an unsplit axis");

  a_row_needs_split: assert property (@(posedge clk) disable iff (rst)
    b_valid && row |-> b_rows.two)
    else $error("second row issued for an unsplit axis");

  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last && !load |=> !b_valid)
    else $error("request still held after its last rectangle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("new split loaded over a request in progress");
`endif

endmodule
